[rtl/core/text_console_character_writer_unit_assert.svh]
`ifndef TEXT_CONSOLE_CHARACTER_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CHARACTER_WRITER_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define TCW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcw check failed");

// consequent checked in the cycle after the antecedent
`define TCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcw check failed");

`endif

[rtl/core/tcw_pkg.sv]
package tcw_pkg;

  localparam int COLUMNS_DEF   = 80;
  localparam int ROWS_DEF      = 24;
  localparam int TAB_WIDTH_DEF = 8;

  localparam int ACTION_W   = 2;
  localparam int CHAR_W     = 8;
  localparam int ROW_PORT_W = 5;
  localparam int COL_PORT_W = 7;

  localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] CODE_BACK    = 8'd8;
  localparam logic [CHAR_W-1:0] CODE_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CODE_ERASE   = 8'h0e;
  localparam logic [CHAR_W-1:0] CODE_SPACE   = 8'h20;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PRINT,
    OP_TAB,
    OP_NEWLINE,
    OP_ERASE,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_CHAR,
    ST_TAB,
    ST_LINE,
    ST_ERASE,
    ST_READ,
    ST_SCROLL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic fill_step;
    logic put_char;
    logic put_tab;
    logic new_line;
    logic erase;
    logic read_capture;
    logic scroll_step;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic row_valid;
    logic row_zero;
    logic fill_last;
    logic tab_last;
    logic rsp_free;
  } status_t;

endpackage

[rtl/core/text_console_character_writer_unit.sv]
// Text console writer: ROWS x COLUMNS character store with a cursor.
// Request channel (req_valid/req_stall) carries action, char_code,
// erase_allowed, cell_row and cell_col; one response per request comes back
// on rsp_valid/rsp_stall with the cursor after the step, the byte read back
// (read action only) and a scroll flag.
// The sequencer steps the single write port of the character memory
// through each request: a printable on a blank row first sweeps that
// row to spaces, a tab writes spaces into 1 to TAB_WIDTH cells, and a
// clear scrolls once per cursor row until the cursor reaches the top.
// Rows sit in a circular buffer with a valid bit per row, so a blank row
// is swept to spaces only when first written, and a scroll moves the base.
// The next request is taken once the current one has its response in the
// output register; a stalled response holds and blocks only the request
// after next.
// Reset homes the cursor and marks every row blank; the store reads as
// spaces at once, with no clearing pass.
module text_console_character_writer_unit #(
  parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS      = tcw_pkg::ROWS_DEF,
  parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic [tcw_pkg::ACTION_W-1:0]     action,
  input  logic [tcw_pkg::CHAR_W-1:0]       char_code,
  input  logic                             erase_allowed,
  input  logic [tcw_pkg::ROW_PORT_W-1:0]   cell_row,
  input  logic [tcw_pkg::COL_PORT_W-1:0]   cell_col,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic [tcw_pkg::ROW_PORT_W-1:0]   cursor_row_now,
  output logic [tcw_pkg::COL_PORT_W-1:0]   cursor_col_now,
  output logic [tcw_pkg::CHAR_W-1:0]       cell_char,
  output logic                             did_scroll
);
  import tcw_pkg::*;

  cmd_t    cmd;
  status_t status;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tcw_datapath #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .action         (action),
    .char_code      (char_code),
    .erase_allowed  (erase_allowed),
    .cell_row       (cell_row),
    .cell_col       (cell_col),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .cursor_row_now (cursor_row_now),
    .cursor_col_now (cursor_col_now),
    .cell_char      (cell_char),
    .did_scroll     (did_scroll)
  );

endmodule

[rtl/core/tcw_ctrl.sv]
module tcw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  tcw_pkg::status_t  status,
  output tcw_pkg::cmd_t     cmd
);
  import tcw_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.accept = 1'b1;
          unique case (status.op)
            OP_PRINT:   state_next = status.row_valid ? ST_CHAR : ST_FILL;
            OP_TAB:     state_next = ST_TAB;
            OP_NEWLINE: state_next = ST_LINE;
            OP_ERASE:   state_next = ST_ERASE;
            OP_READ:    state_next = ST_READ;
            OP_CLEAR:   state_next = ST_SCROLL;
            default:    state_next = ST_DONE;
          endcase
        end
      end
      // blank row gets swept to spaces before its first character lands
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.fill_last) begin
          state_next = ST_CHAR;
        end
      end
      ST_CHAR: begin
        cmd.put_char = 1'b1;
        state_next   = ST_DONE;
      end
      ST_TAB: begin
        cmd.put_tab = 1'b1;
        if (status.tab_last) begin
          state_next = ST_DONE;
        end
      end
      ST_LINE: begin
        cmd.new_line = 1'b1;
        state_next   = ST_DONE;
      end
      ST_ERASE: begin
        cmd.erase  = 1'b1;
        state_next = ST_DONE;
      end
      ST_READ: begin
        cmd.read_capture = 1'b1;
        state_next       = ST_DONE;
      end
      // one scroll per cycle until the cursor row reaches the top
      ST_SCROLL: begin
        if (status.row_zero) begin
          state_next = ST_DONE;
        end else begin
          cmd.scroll_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (status.rsp_free) begin
          cmd.load_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[rtl/core/tcw_datapath.sv]
module tcw_datapath #(
  parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS      = tcw_pkg::ROWS_DEF,
  parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  tcw_pkg::cmd_t                    cmd,
  output tcw_pkg::status_t                 status,
  input  logic [tcw_pkg::ACTION_W-1:0]     action,
  input  logic [tcw_pkg::CHAR_W-1:0]       char_code,
  input  logic                             erase_allowed,
  input  logic [tcw_pkg::ROW_PORT_W-1:0]   cell_row,
  input  logic [tcw_pkg::COL_PORT_W-1:0]   cell_col,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic [tcw_pkg::ROW_PORT_W-1:0]   cursor_row_now,
  output logic [tcw_pkg::COL_PORT_W-1:0]   cursor_col_now,
  output logic [tcw_pkg::CHAR_W-1:0]       cell_char,
  output logic                             did_scroll
);
  import tcw_pkg::*;

  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int PH_W   = $clog2(TAB_WIDTH);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = 2 ** ADDR_W;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
  localparam logic [PH_W-1:0]  PH_LAST  = PH_W'(TAB_WIDTH - 1);
  localparam logic [ROW_W:0]   ROWS_EXT = (ROW_W + 1)'(ROWS);

  // rows live in a circular buffer; base is the physical row shown on top
  function automatic logic [ROW_W-1:0] to_phys(input logic [ROW_W-1:0] r,
                                               input logic [ROW_W-1:0] b);
    logic [ROW_W:0] sum;
    sum = {1'b0, r} + {1'b0, b};
    if (sum >= ROWS_EXT) begin
      sum = sum - ROWS_EXT;
    end
    return sum[ROW_W-1:0];
  endfunction

  logic [CHAR_W-1:0] mem [DEPTH];
  logic [CHAR_W-1:0] rd_data;

  logic [ROW_W-1:0] cursor_row, cursor_row_next;
  logic [COL_W-1:0] cursor_col, cursor_col_next;
  logic [PH_W-1:0]  phase, phase_next;
  logic [ROW_W-1:0] base, base_next;
  logic [ROWS-1:0]  row_valid, row_valid_next;
  logic             scrolled, scrolled_next;
  logic             rsp_valid_next;

  logic [COL_W-1:0]  fill_col, fill_col_next;
  logic [CHAR_W-1:0] cell_byte, cell_byte_next;
  logic [CHAR_W-1:0] code_l;
  logic              rd_in_range;
  logic              rd_row_valid;

  logic [ROW_W-1:0]  cur_phys;
  logic [ROW_W-1:0]  rd_phys;
  logic              rd_range_now;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CHAR_W-1:0] wr_data;
  logic              line_break;
  logic              scroll_now;
  op_t               op;

  assign cur_phys     = to_phys(cursor_row, base);
  assign rd_phys      = to_phys(cell_row[ROW_W-1:0], base);
  assign rd_range_now = (32'(cell_row) < ROWS) && (32'(cell_col) < COLUMNS);

  always_comb begin
    op = OP_NONE;
    unique case (action)
      ACT_PUT: begin
        unique case (char_code) inside
          CODE_NEWLINE:             op = OP_NEWLINE;
          CODE_TAB:                 op = OP_TAB;
          CODE_ERASE:               op = (erase_allowed && cursor_col != '0) ? OP_ERASE : OP_NONE;
          CODE_BACK, CODE_RETURN:   op = OP_NONE;
          default:                  op = OP_PRINT;
        endcase
      end
      ACT_READ:  op = OP_READ;
      ACT_CLEAR: op = OP_CLEAR;
      default:   op = OP_NONE;
    endcase
  end

  always_comb begin
    status.op        = op;
    status.row_valid = row_valid[cur_phys];
    status.row_zero  = (cursor_row == '0);
    status.fill_last = (fill_col == COL_LAST);
    status.tab_last  = (cursor_col == COL_LAST) || (phase == PH_LAST);
    status.rsp_free  = !rsp_valid || !rsp_stall;
  end

  always_comb begin
    cursor_row_next = cursor_row;
    cursor_col_next = cursor_col;
    phase_next      = phase;
    base_next       = base;
    row_valid_next  = row_valid;
    scrolled_next   = scrolled;
    fill_col_next   = fill_col;
    cell_byte_next  = cell_byte;
    wr_en           = 1'b0;
    wr_addr         = {cur_phys, cursor_col};
    wr_data         = CODE_SPACE;
    line_break      = 1'b0;
    scroll_now      = 1'b0;

    if (cmd.accept) begin
      scrolled_next  = 1'b0;
      cell_byte_next = '0;
      fill_col_next  = '0;
    end

    if (cmd.fill_step) begin
      wr_en         = 1'b1;
      wr_addr       = {cur_phys, fill_col};
      fill_col_next = fill_col + COL_W'(1);
      if (fill_col == COL_LAST) begin
        row_valid_next[cur_phys] = 1'b1;
      end
    end

    // printable and tab share the advance-with-wrap rule
    if (cmd.put_char || cmd.put_tab) begin
      wr_en   = 1'b1;
      wr_data = cmd.put_char ? code_l : CODE_SPACE;
      if (cursor_col == COL_LAST) begin
        line_break = 1'b1;
      end else begin
        cursor_col_next = cursor_col + COL_W'(1);
        phase_next      = (phase == PH_LAST) ? '0 : phase + PH_W'(1);
      end
    end

    if (cmd.new_line) begin
      line_break = 1'b1;
    end

    if (cmd.erase) begin
      wr_en           = 1'b1;
      wr_addr         = {cur_phys, cursor_col - COL_W'(1)};
      cursor_col_next = cursor_col - COL_W'(1);
      phase_next      = (phase == '0) ? PH_LAST : phase - PH_W'(1);
    end

    if (cmd.read_capture) begin
      cell_byte_next = rd_in_range ? (rd_row_valid ? rd_data : CODE_SPACE) : '0;
    end

    if (line_break) begin
      cursor_col_next = '0;
      phase_next      = '0;
      if (cursor_row == ROW_LAST) begin
        scroll_now = 1'b1;
      end else begin
        cursor_row_next = cursor_row + ROW_W'(1);
      end
    end

    if (cmd.scroll_step) begin
      scroll_now      = 1'b1;
      cursor_row_next = cursor_row - ROW_W'(1);
    end

    // old top row becomes the new bottom row and reads as blank
    if (scroll_now) begin
      base_next            = (base == ROW_LAST) ? '0 : base + ROW_W'(1);
      row_valid_next[base] = 1'b0;
      scrolled_next        = 1'b1;
    end
  end

  assign rsp_valid_next = cmd.load_result || (rsp_valid && rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_row <= '0;
      cursor_col <= '0;
      phase      <= '0;
      base       <= '0;
      row_valid  <= '0;
      scrolled   <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      cursor_row <= cursor_row_next;
      cursor_col <= cursor_col_next;
      phase      <= phase_next;
      base       <= base_next;
      row_valid  <= row_valid_next;
      scrolled   <= scrolled_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    fill_col  <= fill_col_next;
    cell_byte <= cell_byte_next;
    if (cmd.accept) begin
      code_l       <= char_code;
      rd_in_range  <= rd_range_now;
      rd_row_valid <= row_valid[rd_phys];
    end
    if (cmd.load_result) begin
      cursor_row_now <= ROW_PORT_W'(cursor_row);
      cursor_col_now <= COL_PORT_W'(cursor_col);
      cell_char      <= cell_byte;
      did_scroll     <= scrolled;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[{rd_phys, cell_col[COL_W-1:0]}];
  end

endmodule

[rtl/core/tcw_checker.sv]
`include "text_console_character_writer_unit_assert.svh"

module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             rsp_valid,
  input logic                             rsp_stall,
  input logic [tcw_pkg::ROW_PORT_W-1:0]   cursor_row_now,
  input logic [tcw_pkg::COL_PORT_W-1:0]   cursor_col_now,
  input logic [tcw_pkg::CHAR_W-1:0]       cell_char,
  input logic                             did_scroll
);
  import tcw_pkg::*;

  logic [ROW_PORT_W+COL_PORT_W+CHAR_W:0] rsp_payload;
  logic                                  on_bottom;

  assign rsp_payload = {cursor_row_now, cursor_col_now, cell_char, did_scroll};
  assign on_bottom   = (32'(cursor_row_now) == ROWS - 1);

  // a stalled response keeps its payload
  `TCW_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

  `TCW_ASSERT_NOW(a_row_range, rsp_valid, 32'(cursor_row_now) < ROWS)

  `TCW_ASSERT_NOW(a_col_range, rsp_valid, 32'(cursor_col_now) < COLUMNS)

  // a scroll leaves the cursor on the bottom row, or on top after a clear
  `TCW_ASSERT_NOW(a_scroll_row, rsp_valid && did_scroll, on_bottom || cursor_row_now == '0)

endmodule

bind text_console_character_writer_unit tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (.*);
